### rtl/core/mmio_region_decoder_assert.svh
// ----------------------------------------------------------------------------
// mmio_region_decoder_assert.svh
// Assertion macros shared by the region decoder; clocked on clk, off in rst.
// ----------------------------------------------------------------------------
`ifndef MMIO_REGION_DECODER_ASSERT_SVH
`define MMIO_REGION_DECODER_ASSERT_SVH

// expr holds at every clock edge out of reset
`define MRD_ASSERT_HOLDS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("mmio_region_decoder: invariant violated");

// cons holds in the same cycle as ante
`define MRD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mmio_region_decoder: implication violated");

// cons holds in the cycle after ante
`define MRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mmio_region_decoder: next-cycle implication violated");

`endif

### rtl/core/mrd_pkg.sv
// ----------------------------------------------------------------------------
// mrd_pkg
// Types and codes shared by the MMIO region decoder modules.
// ----------------------------------------------------------------------------
package mrd_pkg;

  // operation codes carried on s_tuser
  localparam logic [1:0] FN_REGISTER = 2'd0;
  localparam logic [1:0] FN_READ     = 2'd1;
  localparam logic [1:0] FN_WRITE    = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_SUCCESS     = 3'd0;
  localparam logic [2:0] STAT_OVERLAP     = 3'd1;
  localparam logic [2:0] STAT_NOT_HANDLED = 3'd2;
  localparam logic [2:0] STAT_DENIED      = 3'd3;
  localparam logic [2:0] STAT_FULL        = 3'd4;

  // permission bits of a stored range
  localparam int PERM_READ  = 0;
  localparam int PERM_WRITE = 1;

  // packed widths of the stream payloads
  localparam int IN_DATA_W  = 208;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 144;
  localparam int OUT_USER_W = 4;

  // one input item
  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] address;
    logic [63:0] range_end;
    logic        read_ok;
    logic        write_ok;
    logic [7:0]  device_tag;
    logic [3:0]  access_len;
    logic [63:0] write_data;
  } item_t;

  // one result item
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  target_tag;
    logic [63:0] target_address;
    logic [3:0]  target_len;
    logic [63:0] target_data;
    logic        is_write;
  } result_t;

  // one table entry as held in the memory
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] range_end;
    logic [1:0]  perms;
    logic [7:0]  tag;
  } entry_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_PRIME,
    S_SHIFT,
    S_INSERT,
    S_DONE
  } ctrl_state_t;

endpackage

### rtl/core/mrd_table_ram.sv
// ----------------------------------------------------------------------------
// mrd_table_ram
// Range table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mrd_table_ram
  import mrd_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data registered from the address of the cycle before
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/mrd_ctrl.sv
// ----------------------------------------------------------------------------
// mrd_ctrl
// Sequencer: scans the sorted table, inserts ranges with a shift-up pass
// and builds one result per item.
// ----------------------------------------------------------------------------
module mrd_ctrl
  import mrd_pkg::*;
#(
  parameter int REGIONS = 16,
  parameter int IW      = 4,
  parameter int CW      = 5
) (
  input  logic          clk,
  input  logic          rst,
  // item side
  input  logic          item_valid,
  output logic          item_ready,
  input  item_t         item_in,
  // result side
  output logic          res_valid,
  input  logic          res_ready,
  output result_t       res,
  // table memory
  output logic          mem_we,
  output logic [IW-1:0] mem_waddr,
  output entry_t        mem_wdata,
  output logic [IW-1:0] mem_raddr,
  input  entry_t        mem_rdata,
  // fill level
  output logic [CW-1:0] entry_count
);

  ctrl_state_t state, state_next;

  item_t         item;
  logic [CW-1:0] count;
  logic [CW-1:0] pos;
  logic [IW-1:0] k;
  logic [63:0]   prev_end;
  logic [1:0]    prev_perms;
  logic [7:0]    prev_tag;

  logic          is_reg;
  logic          in_range;
  logic          scan_hit;
  logic          advance;
  logic          overlap;
  logic          table_full;
  logic          shift_last;
  logic          acc_inside;
  logic          acc_allowed;
  logic          is_wr;
  entry_t        new_entry;
  result_t       res_init;

  assign entry_count = count;

  // scan and insert decisions
  always_comb begin
    is_reg     = (item.func == FN_REGISTER);
    is_wr      = (item.func == FN_WRITE);
    in_range   = (pos < count);
    scan_hit   = is_reg ? (mem_rdata.base < item.address)
                        : (mem_rdata.base <= item.address);
    advance    = in_range && scan_hit;
    overlap    = ((pos != '0) && (item.address < prev_end)) ||
                 (in_range && (mem_rdata.base < item.range_end));
    table_full = (count >= CW'(REGIONS));
    shift_last = ((k - IW'(1)) == pos[IW-1:0]);
    acc_inside = (pos != '0) && (item.address < prev_end);
    acc_allowed = is_wr ? prev_perms[PERM_WRITE] : prev_perms[PERM_READ];
    new_entry.base      = item.address;
    new_entry.range_end = item.range_end;
    new_entry.perms     = {item.write_ok, item.read_ok};
    new_entry.tag       = item.device_tag;
  end

  // result preset on acceptance: full for a register item, else not handled
  always_comb begin
    res_init        = '0;
    res_init.status = (item_in.func == FN_REGISTER) ? STAT_FULL : STAT_NOT_HANDLED;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    res_valid  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = k;
    mem_wdata  = mem_rdata;
    mem_raddr  = '0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        mem_raddr  = '0;
        if (item_valid) begin
          if (item_in.func == FN_REGISTER) begin
            state_next = table_full ? S_DONE : S_SCAN;
          end else if (item_in.func == FN_READ || item_in.func == FN_WRITE) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        // read ahead so that one entry is checked each cycle
        mem_raddr = pos[IW-1:0] + IW'(1);
        if (!advance) begin
          if (!is_reg || overlap) begin
            state_next = S_DONE;
          end else if (pos == count) begin
            state_next = S_INSERT;
          end else begin
            state_next = S_SHIFT_PRIME;
          end
        end
      end
      S_SHIFT_PRIME: begin
        mem_raddr  = k - IW'(1);
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        // move entry k-1 up to k, fetch the next one down
        mem_we    = 1'b1;
        mem_waddr = k;
        mem_wdata = mem_rdata;
        mem_raddr = k - IW'(2);
        if (shift_last) begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        mem_we     = 1'b1;
        mem_waddr  = pos[IW-1:0];
        mem_wdata  = new_entry;
        state_next = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == S_INSERT) begin
      count <= count + CW'(1);
    end
  end

  // item capture, scan position, shift index and result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          item <= item_in;
          pos  <= '0;
          res  <= res_init;
        end
      end
      S_SCAN: begin
        if (advance) begin
          pos        <= pos + CW'(1);
          prev_end   <= mem_rdata.range_end;
          prev_perms <= mem_rdata.perms;
          prev_tag   <= mem_rdata.tag;
        end else if (is_reg) begin
          k <= count[IW-1:0];
          if (overlap) begin
            res.status <= STAT_OVERLAP;
          end
        end else if (acc_inside) begin
          if (!acc_allowed) begin
            res.status <= STAT_DENIED;
          end else begin
            res.status         <= STAT_SUCCESS;
            res.target_tag     <= prev_tag;
            res.target_address <= item.address;
            res.target_len     <= item.access_len;
            res.target_data    <= is_wr ? item.write_data : 64'd0;
            res.is_write       <= is_wr;
          end
        end
      end
      S_SHIFT: begin
        k <= k - IW'(1);
      end
      S_INSERT: begin
        res.status <= STAT_SUCCESS;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/mmio_region_decoder.sv
// ----------------------------------------------------------------------------
// mmio_region_decoder
// MMIO address range table: registers ranges, routes read/write accesses.
// ----------------------------------------------------------------------------
// An access scans the stored ranges, one per cycle through the table read
// port. A register item landing at the top of the table is inserted after the
// scan; one landing lower first primes the read, then moves each entry above
// it up one slot. An overlap ends after the scan; table-full and unknown
// items go straight to the result. One item at a time.
// Reset clears only fill count, sequencer and output valid; no clearing pass.
module mmio_region_decoder
  import mrd_pkg::*;
#(
  parameter int REGIONS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // input items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // address, range_end, read_ok, write_ok, device_tag, access_len, write_data
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // func
  input  logic [IN_USER_W-1:0]  s_tuser,
  // result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // target_tag, target_address, target_len, target_data
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status, is_write
  output logic [OUT_USER_W-1:0] m_tuser
);

  localparam int IW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int CW = $clog2(REGIONS + 1);

  item_t         item_in;
  result_t       res;
  result_t       out_res;
  logic          res_valid;
  logic          res_ready;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_raddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;
  logic [CW-1:0] entry_count;

  // unpack input item
  always_comb begin
    item_in.func       = s_tuser[1:0];
    item_in.address    = s_tdata[63:0];
    item_in.range_end  = s_tdata[127:64];
    item_in.read_ok    = s_tdata[128];
    item_in.write_ok   = s_tdata[129];
    item_in.device_tag = s_tdata[137:130];
    item_in.access_len = s_tdata[141:138];
    item_in.write_data = s_tdata[205:142];
  end

  mrd_ctrl #(
    .REGIONS (REGIONS),
    .IW      (IW),
    .CW      (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (s_tvalid),
    .item_ready  (s_tready),
    .item_in     (item_in),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .entry_count (entry_count)
  );

  mrd_table_ram #(
    .DEPTH (REGIONS),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register; frees the sequencer as soon as a result is taken
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  // pack result item
  assign m_tdata = {4'd0, out_res.target_data, out_res.target_len,
                    out_res.target_address, out_res.target_tag};
  assign m_tuser = {out_res.is_write, out_res.status};

`include "mmio_region_decoder_assert.svh"

  // table never fills past its depth
  `MRD_ASSERT_HOLDS(a_count_bound, entry_count <= CW'(REGIONS))
  // fill count only ever grows by one entry
  `MRD_ASSERT_IMP(a_count_step, !$stable(entry_count), entry_count == CW'($past(entry_count) + CW'(1)))
  // an accepted item leaves the sequencer busy in the next cycle
  `MRD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // only a successful access forwards anything to a device
  `MRD_ASSERT_IMP(a_quiet_on_fail, m_tvalid && m_tuser[2:0] != STAT_SUCCESS, m_tdata == '0 && !m_tuser[3])

endmodule

### verif/tb_mmio_region_decoder.sv
// ----------------------------------------------------------------------------
// tb_mmio_region_decoder
// Self-checking bench for the MMIO range table. Items are queued up front,
// then driven on the input stream with random gaps. Each accepted item is run
// through a local copy of the range table to predict its result, and results
// are checked field by field in order. The result side stalls at random and
// once holds off for a long stretch so the block backs up onto its input.
// ----------------------------------------------------------------------------
module tb_mmio_region_decoder;
  import mrd_pkg::*;

  localparam int REGIONS     = 16;
  localparam int N_RANDOM    = 700;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_AT     = 60;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN       = 40;
  localparam logic [1:0] FN_UNKNOWN = 2'd3;
  localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    item_t item;
    int    gap;
  } pending_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  // stimulus and predicted results
  pending_t item_queue[$];
  result_t  routed_results[$];
  int       total_items = 0;
  int       items_taken = 0;
  int       results_seen = 0;
  int       mismatches = 0;
  int       strays = 0;
  int       n_success = 0, n_overlap = 0, n_unhandled = 0, n_denied = 0, n_full = 0;
  bit       tx_burst = 1'b0;

  // handshake flags from the last rising edge
  logic     in_fire = 1'b0;
  logic     out_fire = 1'b0;
  int       tx_gap = 0;
  int       out_wait = 0;
  int       stall_cycles = 0;

  // local copy of the range table, sorted by base
  logic [63:0] tbl_base[REGIONS];
  logic [63:0] tbl_end[REGIONS];
  logic [1:0]  tbl_perm[REGIONS];
  logic [7:0]  tbl_tag[REGIONS];
  int          tbl_count = 0;

  mmio_region_decoder #(.REGIONS(REGIONS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predict one item's result and update the table copy
  task automatic route_item(input item_t it, output result_t r);
    int pos;
    int k;
    r = '0;
    r.status = STAT_NOT_HANDLED;
    case (it.func)
      FN_REGISTER: begin
        if (tbl_count >= REGIONS) begin
          r.status = STAT_FULL;
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_base[pos] < it.address) pos++;
          if (pos > 0 && it.address < tbl_end[pos-1]) begin
            r.status = STAT_OVERLAP;
          end else if (pos < tbl_count && tbl_base[pos] < it.range_end) begin
            r.status = STAT_OVERLAP;
          end else begin
            // open a slot at pos, new range goes ahead of equal bases
            for (k = tbl_count; k > pos; k--) begin
              tbl_base[k] = tbl_base[k-1];
              tbl_end[k]  = tbl_end[k-1];
              tbl_perm[k] = tbl_perm[k-1];
              tbl_tag[k]  = tbl_tag[k-1];
            end
            tbl_base[pos] = it.address;
            tbl_end[pos]  = it.range_end;
            tbl_perm[pos][PERM_READ]  = it.read_ok;
            tbl_perm[pos][PERM_WRITE] = it.write_ok;
            tbl_tag[pos]  = it.device_tag;
            tbl_count++;
            r.status = STAT_SUCCESS;
          end
        end
      end
      FN_READ, FN_WRITE: begin
        // candidate is the last slot whose base is not above the address
        pos = 0;
        while (pos < tbl_count && tbl_base[pos] <= it.address) pos++;
        if (pos > 0 && it.address < tbl_end[pos-1]) begin
          if (!tbl_perm[pos-1][(it.func == FN_WRITE) ? PERM_WRITE : PERM_READ]) begin
            r.status = STAT_DENIED;
          end else begin
            r.status         = STAT_SUCCESS;
            r.target_tag     = tbl_tag[pos-1];
            r.target_address = it.address;
            r.target_len     = it.access_len;
            r.target_data    = (it.func == FN_WRITE) ? it.write_data : 64'd0;
            r.is_write       = (it.func == FN_WRITE);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic item_t mk_reg(logic [63:0] b, logic [63:0] e, logic rd, logic wr,
                                   logic [7:0] tag);
    item_t it;
    it.func       = FN_REGISTER;
    it.address    = b;
    it.range_end  = e;
    it.read_ok    = rd;
    it.write_ok   = wr;
    it.device_tag = tag;
    it.access_len = 4'($urandom_range(1, 8));
    it.write_data = rand64();
    return it;
  endfunction

  function automatic item_t mk_acc(logic [1:0] fn, logic [63:0] a);
    item_t it;
    it.func       = fn;
    it.address    = a;
    it.range_end  = rand64();
    it.read_ok    = 1'($urandom_range(0, 1));
    it.write_ok   = 1'($urandom_range(0, 1));
    it.device_tag = 8'($urandom);
    it.access_len = 4'($urandom_range(1, 8));
    it.write_data = rand64();
    return it;
  endfunction

  task automatic queue_item(input item_t it);
    pending_t p;
    p.item = it;
    p.gap  = tx_burst ? 0 : $urandom_range(0, 17);
    item_queue.push_back(p);
    total_items++;
  endtask

  // input side: present queued items, idle for each item's gap between them
  always @(negedge clk) begin : tx_side
    pending_t p;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap   <= 0;
    end else if (!s_tvalid || in_fire) begin
      if (tx_gap > 0) begin
        s_tvalid <= 1'b0;
        tx_gap   <= tx_gap - 1;
      end else if (item_queue.size() > 0) begin
        p = item_queue.pop_front();
        s_tdata  <= {2'b00, p.item.write_data, p.item.access_len, p.item.device_tag,
                     p.item.write_ok, p.item.read_ok, p.item.range_end, p.item.address};
        s_tuser  <= p.item.func;
        s_tvalid <= 1'b1;
        tx_gap   <= p.gap;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result side: random stalls per item, one long hold-off
  always @(negedge clk) begin : rx_side
    int w;
    if (rst) begin
      m_tready <= 1'b0;
      out_wait <= 0;
    end else if (out_fire) begin
      if (results_seen == HOLD_AT) w = LONG_HOLD;
      else if ((results_seen / 50) % 3 == 0) w = 0;
      else w = $urandom_range(0, 17);
      if (w == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        out_wait <= w;
      end
    end else if (!m_tready) begin
      if (out_wait > 1) out_wait <= out_wait - 1;
      else m_tready <= 1'b1;
    end
  end

  // sample both handshakes: predict on input, check on output
  always @(posedge clk) begin : monitor
    item_t   it;
    result_t want;
    result_t got;
    in_fire  <= !rst && s_tvalid && s_tready;
    out_fire <= !rst && m_tvalid && m_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        it.func       = s_tuser[1:0];
        it.address    = s_tdata[63:0];
        it.range_end  = s_tdata[127:64];
        it.read_ok    = s_tdata[128];
        it.write_ok   = s_tdata[129];
        it.device_tag = s_tdata[137:130];
        it.access_len = s_tdata[141:138];
        it.write_data = s_tdata[205:142];
        route_item(it, want);
        case (want.status)
          STAT_SUCCESS: n_success++;
          STAT_OVERLAP: n_overlap++;
          STAT_DENIED:  n_denied++;
          STAT_FULL:    n_full++;
          default:      n_unhandled++;
        endcase
        routed_results.push_back(want);
        items_taken++;
      end
      if (m_tvalid && m_tready) begin
        got.status         = m_tuser[2:0];
        got.is_write       = m_tuser[3];
        got.target_tag     = m_tdata[7:0];
        got.target_address = m_tdata[71:8];
        got.target_len     = m_tdata[75:72];
        got.target_data    = m_tdata[139:76];
        results_seen++;
        if (routed_results.size() == 0) begin
          strays++;
          $display("result %0d with nothing outstanding: status %0d tag %0h",
                   results_seen, got.status, got.target_tag);
        end else begin
          want = routed_results.pop_front();
          if (got.status != want.status || got.target_tag != want.target_tag ||
              got.target_address != want.target_address ||
              got.target_len != want.target_len || got.target_data != want.target_data ||
              got.is_write != want.is_write) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: exp st=%0d tag=%h adr=%h len=%0d dat=%h wr=%0b",
                       results_seen, want.status, want.target_tag, want.target_address,
                       want.target_len, want.target_data, want.is_write,
                       "\n    got st=%0d tag=%h adr=%h len=%0d dat=%h wr=%0b",
                       got.status, got.target_tag, got.target_address,
                       got.target_len, got.target_data, got.is_write);
          end
        end
      end
    end
  end

  // watchdog: no handshake for too long while work is outstanding
  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (s_tvalid || routed_results.size() > 0) begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", stall_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : run
    logic [63:0] hist_base[$];
    logic [63:0] hist_end[$];
    logic [63:0] b, e, a;
    logic [1:0]  fn;
    int          i, sel, idx;

    // directed: empty table, unknown op, extremes, overlaps, equal bases
    queue_item(mk_acc(FN_READ, 64'd0));
    queue_item(mk_acc(FN_WRITE, ALL_ONES));
    queue_item(mk_acc(FN_UNKNOWN, rand64()));
    queue_item(mk_reg(64'd0, 64'h40, 1'b1, 1'b0, 8'h00));
    queue_item(mk_reg(ALL_ONES - 64'hF, ALL_ONES, 1'b0, 1'b1, 8'hFF));
    queue_item(mk_reg(64'h20, 64'h80, 1'b1, 1'b1, 8'h21));        // overlaps below
    queue_item(mk_reg(64'h1000, 64'h1100, 1'b1, 1'b1, 8'h5A));
    queue_item(mk_reg(64'h0F80, 64'h1001, 1'b1, 1'b1, 8'h22));    // overlaps above
    queue_item(mk_reg(64'h2000, 64'h1000, 1'b1, 1'b1, 8'h11));    // degenerate
    queue_item(mk_reg(64'h1000, 64'h0800, 1'b1, 1'b1, 8'h33));    // equal base, degenerate
    queue_item(mk_acc(FN_READ, 64'h1000));                         // picks last equal base
    queue_item(mk_reg(64'h40, 64'h40, 1'b1, 1'b1, 8'h44));        // zero length, abutting
    queue_item(mk_reg(ALL_ONES, 64'd0, 1'b1, 1'b1, 8'h55));       // degenerate at the top
    begin
      item_t w;
      w = mk_acc(FN_WRITE, 64'h10FF);
      w.access_len = 4'd8;
      w.write_data = ALL_ONES;
      queue_item(w);
      w = mk_acc(FN_READ, 64'h3F);
      w.access_len = 4'd1;
      w.write_data = 64'd0;
      queue_item(w);
    end
    queue_item(mk_acc(FN_READ, 64'h1100));                         // end is exclusive
    queue_item(mk_acc(FN_READ, 64'h2000));                         // degenerate never hits
    queue_item(mk_acc(FN_WRITE, 64'h0));                           // read-only range
    queue_item(mk_acc(FN_READ, ALL_ONES - 64'h1));                 // write-only range
    queue_item(mk_acc(FN_WRITE, ALL_ONES - 64'h1));
    queue_item(mk_acc(FN_WRITE, ALL_ONES));
    queue_item(mk_acc(FN_READ, 64'h800));                          // gap between ranges

    // random: mostly ranges in a busy window and accesses near their edges
    for (i = 0; i < N_RANDOM; i++) begin
      if (i % 40 == 0) tx_burst = ($urandom_range(0, 2) == 0);
      sel = $urandom_range(0, 99);
      fn  = $urandom_range(0, 1) ? FN_WRITE : FN_READ;
      if (sel < 15) begin
        b = 64'h1_0000 + $urandom_range(0, 'h7FFF);
        e = ($urandom_range(0, 9) == 0) ? b - $urandom_range(0, 16)
                                         : b + $urandom_range(1, 'h800);
        hist_base.push_back(b);
        hist_end.push_back(e);
        queue_item(mk_reg(b, e, 1'($urandom), 1'($urandom), 8'($urandom)));
      end else if (sel < 20 && hist_base.size() > 0) begin
        // deliberately start inside or at a known range
        idx = $urandom_range(0, hist_base.size() - 1);
        b = hist_base[idx] + $urandom_range(0, 3);
        queue_item(mk_reg(b, b + $urandom_range(1, 'h100), 1'($urandom), 1'($urandom),
                          8'($urandom)));
      end else if (sel < 25) begin
        queue_item(mk_reg(rand64(), rand64(), 1'($urandom), 1'($urandom), 8'($urandom)));
      end else if (sel < 30) begin
        queue_item(mk_acc(FN_UNKNOWN, rand64()));
      end else if (sel < 40) begin
        queue_item(mk_acc(fn, rand64()));
      end else if (hist_base.size() == 0) begin
        queue_item(mk_acc(fn, 64'h1_0000 + $urandom_range(0, 'h8800)));
      end else begin
        idx = $urandom_range(0, hist_base.size() - 1);
        b = hist_base[idx];
        e = hist_end[idx];
        case ($urandom_range(0, 5))
          0: a = b;
          1: a = e - 64'd1;
          2: a = e;
          3: a = b - 64'd1;
          4: a = (e > b) ? b + (rand64() % (e - b)) : b;
          default: a = 64'h1_0000 + $urandom_range(0, 'h8800);
        endcase
        queue_item(mk_acc(fn, a));
      end
    end

    // fill to capacity in an untouched area, then probe the full table
    tx_burst = 1'b0;
    for (i = 0; i < 20; i++) begin
      b = 64'h1_0000_0000 + 64'(i) * 64'h100;
      queue_item(mk_reg(b, b + 64'h10, 1'($urandom), 1'($urandom), 8'($urandom)));
    end
    for (i = 0; i < 4; i++)
      queue_item(mk_acc(i[0] ? FN_WRITE : FN_READ, 64'h1_0000_0000 + 64'(i) * 64'h100));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (items_taken < total_items) @(posedge clk);
    while (routed_results.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("%0d items, %0d results: %0d success, %0d overlap, %0d not handled,",
             items_taken, results_seen, n_success, n_overlap, n_unhandled);
    $display("  %0d denied, %0d table full; %0d mismatches, %0d stray results",
             n_denied, n_full, mismatches, strays);
    if (mismatches == 0 && strays == 0 && routed_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
